// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked out of reset
`define BMF_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication checked at every edge, reset included
`define BMF_ASSERT_NEXT(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/bmf_pkg.sv =====
// package with shared types and constants of the box mean filter
`timescale 1ns / 1ps
package bmf_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int PIX_W      = 24;
    localparam int SUM_W      = 14;
    localparam int RECIP_W    = 21;
    localparam int RECIP_SH   = 20;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [RECIP_W-1:0] t_recip;

    // reciprocal of the window area (2r+1)^2, scaled by 2^20 and rounded up
    function automatic t_recip recip_of(input logic [1:0] rad);
        t_recip v;
        v = '0;
        case (rad)
            2'd0:    v = 21'd1048576;
            2'd1:    v = 21'd116509;
            2'd2:    v = 21'd41944;
            2'd3:    v = 21'd21400;
            default: v = 21'd1048576;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/bmf_in_if.sv =====
// pixel input channel
`timescale 1ns / 1ps
interface bmf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source(output valid, mode, blue_in, green_in, red_in, input ready);
    modport sink(input valid, mode, blue_in, green_in, red_in, output ready);
endinterface

// ===== rtl/core/bmf_out_if.sv =====
// pixel result channel
`timescale 1ns / 1ps
interface bmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_pixel;

    modport source(output valid, blue_out, green_out, red_out, last_pixel, input ready);
    modport sink(input valid, blue_out, green_out, red_out, last_pixel, output ready);
endinterface

// ===== rtl/core/rgb_box_mean_filter_core.sv =====
// box mean filter top level: counters, window read sequencer, divide and output
//
//  channel   dir   handshake          payload
//  i_pix     in    valid / ready      mode, blue_in, green_in, red_in
//  o_pix     out   valid / ready      blue_out, green_out, red_out, last_pixel
//  cfg       in    i_cfg_we           i_cfg_idx, i_cfg_data
//
// an item that gives a result reads its (2r'+1)^2 window pixels, r' = radius
// inside the image and 0 at its edges, through the single read port of the
// line store (one window pixel a cycle)
// reset is synchronous and active low; the line store is not cleared
// input is taken while a finished result waits in the output register;
// a new result stalls in S_OUT until the waiting one is transferred
`timescale 1ns / 1ps
module rgb_box_mean_filter_core
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmf_in_if.sink                i_pix,
    bmf_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int RW        = $clog2(LINE_ROWS);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int FW        = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_WAIT, S_MUL, S_OUT} t_state;

    t_state r_state;

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [1:0]  r_radius;

    logic [15:0]   r_in_row, r_out_row;
    logic [CW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_rmod, r_out_rmod;
    logic [FW-1:0] r_fill;

    logic [RW-1:0] r_rrow;
    logic [CW-1:0] r_rcol, r_rcol0;
    logic [2:0]    r_xcnt, r_ycnt, r_side_m1;
    logic [1:0]    r_ruse;
    logic          r_rd_vld;
    logic          r_last;
    t_sum          r_sum_b, r_sum_g, r_sum_r;
    logic [SUM_W+RECIP_W-1:0] r_prod_b, r_prod_g, r_prod_r;

    logic       r_ovalid;
    logic [7:0] r_oblue, r_ogreen, r_ored;
    logic       r_olast;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [1:0]    rad;
    logic [FW-1:0] delay_px;
    logic          in_xfer, in_pix, past_delay, flush_emit, emit, in_win, out_last;
    logic [1:0]    n_ruse;
    logic [RW-1:0] n_rrow;
    logic          in_col_wrap, out_col_wrap;
    t_pix          rdata;
    t_recip        recip;

    // effective sizes
    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
        rad   = (32'(r_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : r_radius;
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign in_xfer     = i_pix.valid && i_pix.ready;

    // item decode and window setup
    always_comb begin
        in_pix     = !i_pix.mode && (r_in_row < h_eff);
        // pixels taken so far in this frame against r rows and r columns of delay
        delay_px   = FW'(32'(rad) * 32'(w_eff) + 32'(rad));
        past_delay = (r_fill >= delay_px);
        flush_emit = (r_in_row >= h_eff) && (r_out_row < h_eff);
        emit       = in_pix ? past_delay : flush_emit;
        in_win     = (32'(r_out_row) >= 32'(rad))
                     && (32'(r_out_row) + 32'(rad) < 32'(h_eff))
                     && (32'(r_out_col) >= 32'(rad))
                     && (32'(r_out_col) + 32'(rad) < 32'(w_eff));
        n_ruse     = in_win ? rad : 2'd0;
        if (r_out_rmod >= RW'(n_ruse)) begin
            n_rrow = r_out_rmod - RW'(n_ruse);
        end else begin
            n_rrow = RW'(32'(r_out_rmod) + LINE_ROWS - 32'(n_ruse));
        end
        out_last     = (32'(r_out_row) + 1 == 32'(h_eff))
                       && (32'(r_out_col) + 1 == 32'(w_eff));
        in_col_wrap  = (32'(r_in_col) + 1 >= 32'(w_eff));
        out_col_wrap = (32'(r_out_col) + 1 >= 32'(w_eff));
        recip        = recip_of(r_ruse);
    end

    bmf_line_mem #(
        .ROWS  (LINE_ROWS),
        .COL_W (CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (in_xfer && in_pix),
        .i_waddr ({r_in_rmod, r_in_col}),
        .i_wdata ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
        .i_raddr ({r_rrow, r_rcol}),
        .o_rdata (rdata)
    );

    // window sums over the read data
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sum_b <= '0;
            r_sum_g <= '0;
            r_sum_r <= '0;
        end else if (r_rd_vld) begin
            r_sum_b <= r_sum_b + SUM_W'(rdata[7:0]);
            r_sum_g <= r_sum_g + SUM_W'(rdata[15:8]);
            r_sum_r <= r_sum_r + SUM_W'(rdata[23:16]);
        end
    end

    // divide by the window area through its reciprocal
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod_b <= (SUM_W+RECIP_W)'(r_sum_b) * (SUM_W+RECIP_W)'(recip);
            r_prod_g <= (SUM_W+RECIP_W)'(r_sum_g) * (SUM_W+RECIP_W)'(recip);
            r_prod_r <= (SUM_W+RECIP_W)'(r_sum_r) * (SUM_W+RECIP_W)'(recip);
        end
    end

    // control, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_width    <= 11'd640;
            r_height   <= 16'd480;
            r_radius   <= 2'd1;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_rmod  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_rmod <= '0;
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            if (r_ovalid && o_pix.ready) begin
                r_ovalid <= 1'b0;
            end

            // a write to any of the three configuration registers restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[10:0];
                    CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[15:0];
                    CFG_WINDOW_RADIUS: r_radius <= i_cfg_data[1:0];
                    default:           ;
                endcase
                if (i_cfg_idx inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_RADIUS}) begin
                    r_in_row   <= '0;
                    r_in_col   <= '0;
                    r_in_rmod  <= '0;
                    r_out_row  <= '0;
                    r_out_col  <= '0;
                    r_out_rmod <= '0;
                    r_fill     <= '0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (in_pix) begin
                            if (!past_delay) begin
                                r_fill <= r_fill + FW'(1);
                            end
                            if (in_col_wrap) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + 16'd1;
                                r_in_rmod <= (32'(r_in_rmod) + 1 == LINE_ROWS)
                                             ? '0 : r_in_rmod + RW'(1);
                            end else begin
                                r_in_col <= r_in_col + CW'(1);
                            end
                        end
                        if (emit) begin
                            r_ruse    <= n_ruse;
                            r_side_m1 <= {n_ruse, 1'b0};
                            r_rrow    <= n_rrow;
                            r_rcol    <= r_out_col - CW'(n_ruse);
                            r_rcol0   <= r_out_col - CW'(n_ruse);
                            r_xcnt    <= '0;
                            r_ycnt    <= '0;
                            r_last    <= out_last;
                            r_state   <= S_READ;
                            if (out_last) begin
                                r_in_row   <= '0;
                                r_in_col   <= '0;
                                r_in_rmod  <= '0;
                                r_out_row  <= '0;
                                r_out_col  <= '0;
                                r_out_rmod <= '0;
                                r_fill     <= '0;
                            end else if (out_col_wrap) begin
                                r_out_col  <= '0;
                                r_out_row  <= r_out_row + 16'd1;
                                r_out_rmod <= (32'(r_out_rmod) + 1 == LINE_ROWS)
                                              ? '0 : r_out_rmod + RW'(1);
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                        end
                    end
                end
                S_READ: begin
                    // one window pixel read per cycle, row by row
                    if (r_ycnt == r_side_m1) begin
                        r_ycnt <= '0;
                        r_rcol <= r_rcol0;
                        r_rrow <= (32'(r_rrow) + 1 == LINE_ROWS) ? '0 : r_rrow + RW'(1);
                        r_xcnt <= r_xcnt + 3'd1;
                        if (r_xcnt == r_side_m1) begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_ycnt <= r_ycnt + 3'd1;
                        r_rcol <= r_rcol + CW'(1);
                    end
                end
                S_WAIT: r_state <= S_MUL;
                S_MUL:  r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || o_pix.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || o_pix.ready)) begin
            r_oblue  <= r_prod_b[RECIP_SH +: 8];
            r_ogreen <= r_prod_g[RECIP_SH +: 8];
            r_ored   <= r_prod_r[RECIP_SH +: 8];
            r_olast  <= r_last;
        end
    end

    assign o_pix.valid      = r_ovalid;
    assign o_pix.blue_out   = r_oblue;
    assign o_pix.green_out  = r_ogreen;
    assign o_pix.red_out    = r_ored;
    assign o_pix.last_pixel = r_olast;
endmodule

// ===== rtl/core/bmf_line_mem.sv =====
// line store memory, one write and one registered read port
`timescale 1ns / 1ps
module bmf_line_mem
    import bmf_pkg::*;
#(
    parameter int ROWS  = 7,
    parameter int COL_W = 10
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(ROWS)+COL_W-1:0]   i_waddr,
    input  t_pix                            i_wdata,
    input  logic [$clog2(ROWS)+COL_W-1:0]   i_raddr,
    output t_pix                            o_rdata
);
    localparam int DEPTH = ROWS * (2 ** COL_W);

    t_pix r_mem [0:DEPTH-1];
    t_pix r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/bmf_checker.sv =====
// port checker for the box mean filter and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [24:0] i_out_data
);
    // a result waiting for transfer stays offered
    `BMF_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, $past(i_out_valid && !i_out_ready) && $past(i_rst_n), i_out_valid)
    // a stalled result keeps its payload
    `BMF_ASSERT_IMPLY(a_out_stable, i_clk, i_rst_n, $past(i_out_valid && !i_out_ready) && $past(i_rst_n), $stable(i_out_data))
    // no result appears right after an input transfer
    `BMF_ASSERT_IMPLY(a_out_latency, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready))
    // reset empties the output register
    `BMF_ASSERT_NEXT(a_rst_clear, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind rgb_box_mean_filter_core bmf_checker u_bmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  ({o_pix.last_pixel, o_pix.red_out, o_pix.green_out, o_pix.blue_out})
);
